@@ hdl/csc_pkg.sv @@
// Shared types and constants for the charge screen controller.
// No dependencies; every other file in hdl imports this package.
package csc_pkg;

	// Frame table geometry
	localparam int MAX_FRAMES = 8;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int FTOTAL_W   = FRAME_W + 1;

	// Status refresh limits, in ticks
	localparam logic [3:0] REFRESH_LIMIT_AWAKE  = 4'd12;
	localparam logic [3:0] REFRESH_LIMIT_ASLEEP = 4'd6;

	// Result action codes
	localparam logic [1:0] ACT_CONTINUE = 2'd0;
	localparam logic [1:0] ACT_BOOT     = 2'd1;
	localparam logic [1:0] ACT_SHUTDOWN = 2'd2;

	// Charger command codes
	localparam logic [1:0] CMD_OFF   = 2'd0;
	localparam logic [1:0] CMD_MODE1 = 2'd1;
	localparam logic [1:0] CMD_MODE2 = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// Charge state codes from the fuel gauge
	localparam logic [1:0] CHG_FAULT = 2'd0;
	localparam logic [1:0] CHG_ALT   = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_LONG_PRESS  = 3'd0;
	localparam logic [2:0] REG_DIM_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_OFF_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_BRIGHT_ON   = 3'd3;
	localparam logic [2:0] REG_BRIGHT_DIM  = 3'd4;
	localparam logic [2:0] REG_FRAME_TABLE = 3'd5;
	localparam logic [2:0] REG_FRAME_TOTAL = 3'd6;

	// Configuration reset values
	localparam logic [15:0] RST_LONG_PRESS  = 16'd1500;
	localparam logic [21:0] RST_DIM_TIMEOUT = 22'd60000;
	localparam logic [21:0] RST_OFF_TIMEOUT = 22'd120000;
	localparam logic [7:0]  RST_BRIGHT_ON   = 8'd48;
	localparam logic [7:0]  RST_BRIGHT_DIM  = 8'd12;
	localparam logic [63:0] RST_FRAME_TABLE = 64'd0;
	localparam logic [3:0]  RST_FRAME_TOTAL = 4'd8;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        charger_present;
		logic        power_key;
		logic [6:0]  battery_capacity;
		logic [1:0]  charge_state_code;
		logic        battery_full;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [1:0]         charger_command;
		logic               backlight_write;
		logic [7:0]         backlight_level;
		logic               standby_write;
		logic               panel_standby;
		logic               show_frame;
		logic [FRAME_W-1:0] frame_index;
	} out_item_t;

	typedef struct packed {
		logic [15:0] long_press_ms;
		logic [21:0] dim_timeout_ms;
		logic [21:0] off_timeout_ms;
		logic [7:0]  bright_on_level;
		logic [7:0]  bright_dim_level;
		logic [63:0] frame_level_table;
		logic [3:0]  frame_total;
	} cfg_t;

endpackage

@@ hdl/charge_screen_controller.sv @@
// Charge screen controller top level: input register, decision core,
// result register. Depends on csc_pkg, csc_cfg, csc_core.
//
// Usage:
//   in_valid/in_stall/in_data carry one charge-loop tick per item; an item
//   is taken at a clock edge with in_valid high and in_stall low.
//   out_valid/out_stall/out_data return exactly one result item per tick,
//   in order; the result is taken when out_valid is high and out_stall low.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the configuration
//   registers (index 0..6); cfg_ready is always high. Write them only
//   while no tick is in flight.
// Pipeline and throughput:
//   A taken tick waits in the input register while the decision logic works
//   on it; the result register then loads the result once it is empty or
//   being taken. One tick per cycle is sustained while out_stall is low;
//   the single pass of decision logic between the two registers sets the
//   cycle.
// Stall behavior:
//   When out_stall holds a result, the input register still takes one more
//   tick; in_stall rises only once both registers are full.
// Reset:
//   arst_n resets all controller state and loads the configuration
//   defaults; the first tick after reset latches the battery status.
module charge_screen_controller import csc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t      cfg;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_data_q;
	out_item_t result;
	logic      advance;
	logic      step;

	csc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Move forward whenever the result register is empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	csc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Input register: load when the held item moves on or the slot is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ hdl/csc_cfg.sv @@
// Configuration register file for the charge screen controller.
// Depends on csc_pkg for the register indexes and reset values.
module csc_cfg import csc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// Always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Write the addressed register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms     <= RST_LONG_PRESS;
			cfg_q.dim_timeout_ms    <= RST_DIM_TIMEOUT;
			cfg_q.off_timeout_ms    <= RST_OFF_TIMEOUT;
			cfg_q.bright_on_level   <= RST_BRIGHT_ON;
			cfg_q.bright_dim_level  <= RST_BRIGHT_DIM;
			cfg_q.frame_level_table <= RST_FRAME_TABLE;
			cfg_q.frame_total       <= RST_FRAME_TOTAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LONG_PRESS:  cfg_q.long_press_ms     <= cfg_data[15:0];
				REG_DIM_TIMEOUT: cfg_q.dim_timeout_ms    <= cfg_data[21:0];
				REG_OFF_TIMEOUT: cfg_q.off_timeout_ms    <= cfg_data[21:0];
				REG_BRIGHT_ON:   cfg_q.bright_on_level   <= cfg_data[7:0];
				REG_BRIGHT_DIM:  cfg_q.bright_dim_level  <= cfg_data[7:0];
				REG_FRAME_TABLE: cfg_q.frame_level_table <= cfg_data;
				REG_FRAME_TOTAL: cfg_q.frame_total       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/csc_frame.sv @@
// Animation frame picker: finds the level group for the battery capacity
// and steps the cursor within it. Depends on csc_pkg.
module csc_frame import csc_pkg::*; (
	input  logic [63:0]        level_table,
	input  logic [3:0]         frame_total,
	input  logic [6:0]         capacity,
	input  logic [FRAME_W-1:0] cursor,
	output logic [FRAME_W-1:0] frame
);

	logic [7:0]          level [MAX_FRAMES];
	logic [FTOTAL_W-1:0] total;
	logic [MAX_FRAMES-1:0] hit;
	logic [FRAME_W-1:0]  start;
	logic [FTOTAL_W-1:0] next;
	logic [7:0]          cap_ext;

	assign cap_ext = {1'b0, capacity};

	// Clamp the frame count to one..MAX_FRAMES
	always_comb begin
		if (frame_total == 4'd0) begin
			total = FTOTAL_W'(1);
		end else if (frame_total > 4'(MAX_FRAMES)) begin
			total = FTOTAL_W'(MAX_FRAMES);
		end else begin
			total = FTOTAL_W'(frame_total);
		end
	end

	// Unpack the levels and compare each against the capacity
	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			level[i] = level_table[i*8 +: 8];
			hit[i]   = (FTOTAL_W'(i) < total) && (cap_ext <= level[i]);
		end
	end

	// Take the lowest matching frame as the group start
	always_comb begin
		start = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				start = FRAME_W'(i);
			end
		end
	end

	assign next = {1'b0, cursor} + FTOTAL_W'(1);

	// Restart the group on a level change or at its end, else advance within it
	always_comb begin
		if (start == '0) begin
			frame = '0;
		end else if (level[cursor] < cap_ext || level[start] != level[cursor]) begin
			frame = start;
		end else if (next >= total || level[start] != level[next[FRAME_W-1:0]]) begin
			frame = start;
		end else begin
			frame = next[FRAME_W-1:0];
		end
	end

endmodule

@@ hdl/csc_core.sv @@
// Per-tick decision logic and controller state: status latch, charger
// command, key handling, screen timers. Depends on csc_pkg and csc_frame.
module csc_core import csc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	// Controller state
	logic               started_q;
	logic [1:0]         finished_q;
	logic [3:0]         refresh_q;
	logic [6:0]         lat_cap_q;
	logic [1:0]         lat_code_q;
	logic               lat_full_q;
	logic               asleep_q;
	logic               holding_q;
	logic [31:0]        hold_start_q;
	logic [31:0]        screen_on_q;
	logic [FRAME_W-1:0] cursor_q;
	logic               pending_q;

	// Next-state values
	logic               started_d;
	logic [1:0]         finished_d;
	logic [3:0]         refresh_d;
	logic [6:0]         lat_cap_d;
	logic [1:0]         lat_code_d;
	logic               lat_full_d;
	logic               asleep_d;
	logic               holding_d;
	logic [31:0]        hold_start_d;
	logic [31:0]        screen_on_d;
	logic [FRAME_W-1:0] cursor_d;
	logic               pending_d;

	logic [3:0]         refresh_inc;
	logic [3:0]         refresh_limit;
	logic               do_latch;
	logic [31:0]        screen_base;
	logic [31:0]        held_for;
	logic [31:0]        on_for;
	logic [FRAME_W-1:0] picked;

	assign refresh_inc   = refresh_q + 4'd1;
	assign refresh_limit = asleep_q ? REFRESH_LIMIT_ASLEEP : REFRESH_LIMIT_AWAKE;
	assign do_latch      = (finished_q == ACT_CONTINUE) &&
		(!started_q || (refresh_inc > refresh_limit));
	assign lat_cap_d     = do_latch ? item.battery_capacity : lat_cap_q;
	assign lat_code_d    = do_latch ? item.charge_state_code : lat_code_q;
	assign lat_full_d    = do_latch ? item.battery_full : lat_full_q;
	assign screen_base   = started_q ? screen_on_q : item.now_ms;
	assign held_for      = item.now_ms - hold_start_q;
	assign on_for        = item.now_ms - screen_base;

	csc_frame u_frame (
		.level_table (cfg.frame_level_table),
		.frame_total (cfg.frame_total),
		.capacity    (lat_cap_d),
		.cursor      (cursor_q),
		.frame       (picked)
	);

	// Decide the tick's result and the next state
	always_comb begin
		result       = '0;
		result.charger_command = CMD_NONE;
		started_d    = started_q;
		finished_d   = finished_q;
		refresh_d    = refresh_q;
		asleep_d     = asleep_q;
		holding_d    = holding_q;
		hold_start_d = hold_start_q;
		screen_on_d  = screen_on_q;
		cursor_d     = cursor_q;
		pending_d    = pending_q;

		if (finished_q != ACT_CONTINUE) begin
			result.action = finished_q;
		end else begin
			started_d   = 1'b1;
			screen_on_d = screen_base;
			if (!started_q) begin
				result.charger_command = (item.charge_state_code == CHG_ALT) ?
					CMD_MODE2 : CMD_MODE1;
			end
			refresh_d = (refresh_inc > refresh_limit) ? 4'd0 : refresh_inc;
			if (lat_code_d == CHG_FAULT || lat_full_d) begin
				result.charger_command = CMD_OFF;
			end

			if (!item.charger_present || lat_code_d == CHG_FAULT) begin
				// Unplug or fault: shut down
				finished_d    = ACT_SHUTDOWN;
				result.action = ACT_SHUTDOWN;
			end else if (item.power_key && holding_q &&
					held_for >= {16'd0, cfg.long_press_ms}) begin
				// Long press: boot with the screen off
				finished_d             = ACT_BOOT;
				result.action          = ACT_BOOT;
				result.backlight_write = 1'b1;
				result.standby_write   = 1'b1;
				result.panel_standby   = 1'b1;
			end else begin
				if (item.power_key) begin
					if (!holding_q) begin
						holding_d    = 1'b1;
						hold_start_d = item.now_ms;
					end
				end else if (holding_q) begin
					holding_d = 1'b0;
					asleep_d  = !asleep_q;
					pending_d = 1'b1;
				end else if (!asleep_q) begin
					if (on_for >= {10'd0, cfg.dim_timeout_ms}) begin
						result.backlight_write = 1'b1;
						result.backlight_level = cfg.bright_dim_level;
					end
					if (on_for >= {10'd0, cfg.off_timeout_ms}) begin
						asleep_d  = 1'b1;
						pending_d = 1'b1;
					end
				end

				if (!asleep_d) begin
					cursor_d           = picked;
					result.show_frame  = 1'b1;
					result.frame_index = picked;
				end

				if (pending_d) begin
					result.backlight_write = 1'b1;
					result.backlight_level = asleep_d ? 8'd0 : cfg.bright_on_level;
					result.standby_write   = 1'b1;
					result.panel_standby   = asleep_d;
					if (!asleep_d) begin
						screen_on_d = item.now_ms;
					end
				end
				pending_d = 1'b0;
			end
		end
	end

	// Commit the state when the item leaves for the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			finished_q   <= ACT_CONTINUE;
			refresh_q    <= 4'd0;
			lat_cap_q    <= 7'd0;
			lat_code_q   <= CHG_FAULT;
			lat_full_q   <= 1'b0;
			asleep_q     <= 1'b0;
			holding_q    <= 1'b0;
			hold_start_q <= 32'd0;
			screen_on_q  <= 32'd0;
			cursor_q     <= '0;
			pending_q    <= 1'b1;
		end else if (step) begin
			started_q    <= started_d;
			finished_q   <= finished_d;
			refresh_q    <= refresh_d;
			lat_cap_q    <= lat_cap_d;
			lat_code_q   <= lat_code_d;
			lat_full_q   <= lat_full_d;
			asleep_q     <= asleep_d;
			holding_q    <= holding_d;
			hold_start_q <= hold_start_d;
			screen_on_q  <= screen_on_d;
			cursor_q     <= cursor_d;
			pending_q    <= pending_d;
		end
	end

	// Once finished, the controller stays finished with the same code
	assert property (@(posedge clk) disable iff (!arst_n)
		finished_q != ACT_CONTINUE |=> finished_q == $past(finished_q))
		else $error("finished code changed after finish");

	// Refresh counter wraps before it passes the awake limit
	assert property (@(posedge clk) disable iff (!arst_n)
		refresh_q <= REFRESH_LIMIT_AWAKE)
		else $error("refresh counter out of range");

	// Started never clears outside reset
	assert property (@(posedge clk) disable iff (!arst_n) !$fell(started_q))
		else $error("started flag cleared");

	// A boot result always blanks the panel
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && finished_q == ACT_CONTINUE && result.action == ACT_BOOT) |->
		(result.backlight_write && result.standby_write && result.panel_standby))
		else $error("boot result without panel blanking");

	// No state moves without a committed item
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(!step) |-> ($stable(asleep_q) && $stable(cursor_q) && $stable(holding_q)))
		else $error("state changed without an item");

endmodule
